// ----- sv/pbc_pkg.sv -----
// ----------------------------------------------------------------------------
// pbc_pkg: power button press classifier shared types and codes
// beat layouts, configuration record, register indexes and field codes
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int unsigned KeyCodeW = 10;
  localparam int unsigned MsW      = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // item kinds
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_EVENT = 2'd1;
  localparam logic [1:0] MODE_WAKE  = 2'd2;

  // key values
  localparam logic [1:0] KEY_RELEASE = 2'd0;
  localparam logic [1:0] KEY_PRESS   = 2'd1;
  localparam logic [1:0] KEY_REPEAT  = 2'd2;

  // actions
  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_SLEEP    = 2'd1;
  localparam logic [1:0] ACT_SHUTDOWN = 2'd2;

  // user messages
  localparam logic [2:0] MSG_NONE        = 3'd0;
  localparam logic [2:0] MSG_COOLING     = 3'd1;
  localparam logic [2:0] MSG_JUST_WOKE   = 3'd2;
  localparam logic [2:0] MSG_STABILIZING = 3'd3;
  localparam logic [2:0] MSG_TOO_RAPID   = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_PWR_KEY_ID  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SHORT_PRESS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_PRESS   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GRACE       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_POST_GRACE  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE    = 3'd6;

  // debounce time left above which a repeated press is flagged
  localparam logic [MsW-1:0] RAPID_THRESH = 16'd150;

  typedef struct packed {
    logic [1:0]          mode;
    logic                is_key_event;
    logic [KeyCodeW-1:0] key_code;
    logic [1:0]          key_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] message;
  } out_beat_t;

  typedef struct packed {
    logic [KeyCodeW-1:0] pwr_key_id;
    logic [MsW-1:0]      short_press_max_ms;
    logic [MsW-1:0]      min_press_ms;
    logic [MsW-1:0]      cooldown_ms;
    logic [MsW-1:0]      grace_ms;
    logic [MsW-1:0]      post_grace_ms;
    logic [MsW-1:0]      debounce_ms;
  } cfg_t;

endpackage

// ----- sv/pbc_stream_if.sv -----
// ----------------------------------------------------------------------------
// pbc_stream_if: valid/ready stream channel
// one beat moves at a rising edge with valid and ready both high
// ----------------------------------------------------------------------------
interface pbc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/pbc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pbc_cfg_regs: configuration register file
// write-only registers loaded by index, reset to their default timings
// ----------------------------------------------------------------------------
module pbc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pbc_pkg::CfgDataW-1:0]  cfg_data_i,
  output pbc_pkg::cfg_t                 cfg_o
);

  pbc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbc_pkg::REG_PWR_KEY_ID:
          cfg_d.pwr_key_id = cfg_data_i[pbc_pkg::KeyCodeW-1:0];
        pbc_pkg::REG_SHORT_PRESS: cfg_d.short_press_max_ms = cfg_data_i;
        pbc_pkg::REG_MIN_PRESS:   cfg_d.min_press_ms       = cfg_data_i;
        pbc_pkg::REG_COOLDOWN:    cfg_d.cooldown_ms        = cfg_data_i;
        pbc_pkg::REG_GRACE:       cfg_d.grace_ms           = cfg_data_i;
        pbc_pkg::REG_POST_GRACE:  cfg_d.post_grace_ms      = cfg_data_i;
        pbc_pkg::REG_DEBOUNCE:    cfg_d.debounce_ms        = cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwr_key_id         <= 10'd116;
      cfg_q.short_press_max_ms <= 16'd2000;
      cfg_q.min_press_ms       <= 16'd50;
      cfg_q.cooldown_ms        <= 16'd2000;
      cfg_q.grace_ms           <= 16'd3000;
      cfg_q.post_grace_ms      <= 16'd1000;
      cfg_q.debounce_ms        <= 16'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/pbc_core.sv -----
// ----------------------------------------------------------------------------
// pbc_core: press classifier state and decision logic
// holds the timing counters and computes one result per advanced beat
// ----------------------------------------------------------------------------
module pbc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  pbc_pkg::in_beat_t   beat_i,
  input  pbc_pkg::cfg_t       cfg_i,
  output pbc_pkg::out_beat_t  res_o
);

  localparam logic [pbc_pkg::MsW-1:0] AgeMax = '1;

  logic                    press_pending_q, press_pending_d;
  logic [pbc_pkg::MsW-1:0] press_age_q, press_age_d;
  logic [pbc_pkg::MsW-1:0] cooldown_q, cooldown_d;
  logic [pbc_pkg::MsW-1:0] grace_q, grace_d;
  logic [pbc_pkg::MsW-1:0] post_grace_q, post_grace_d;
  logic                    grace_ended_q, grace_ended_d;
  logic                    from_wake_q, from_wake_d;
  logic [pbc_pkg::MsW-1:0] debounce_q, debounce_d;

  logic power, release_hit;

  function automatic logic [pbc_pkg::MsW-1:0] dec_sat(input logic [pbc_pkg::MsW-1:0] v);
    return (v != '0) ? v - 1'b1 : v;
  endfunction

  always_comb begin
    power       = beat_i.is_key_event && (beat_i.key_code == cfg_i.pwr_key_id);
    release_hit = power && (beat_i.key_value == pbc_pkg::KEY_RELEASE);

    press_pending_d = press_pending_q;
    press_age_d     = press_age_q;
    cooldown_d      = cooldown_q;
    grace_d         = grace_q;
    post_grace_d    = post_grace_q;
    grace_ended_d   = grace_ended_q;
    from_wake_d     = from_wake_q;
    debounce_d      = debounce_q;
    res_o.action    = pbc_pkg::ACT_NONE;
    res_o.message   = pbc_pkg::MSG_NONE;

    unique case (beat_i.mode)
      pbc_pkg::MODE_TICK: begin
        cooldown_d   = dec_sat(cooldown_q);
        grace_d      = dec_sat(grace_q);
        post_grace_d = dec_sat(post_grace_q);
        debounce_d   = dec_sat(debounce_q);
        if (press_pending_q && (press_age_q != AgeMax)) begin
          press_age_d = press_age_q + 1'b1;
        end
        if (from_wake_q && !grace_ended_q && (grace_d == '0)) begin
          grace_ended_d = 1'b1;
          post_grace_d  = cfg_i.post_grace_ms;
        end
      end
      pbc_pkg::MODE_WAKE: begin
        grace_d         = cfg_i.grace_ms;
        from_wake_d     = 1'b1;
        press_pending_d = 1'b0;
        press_age_d     = '0;
        cooldown_d      = '0;
        debounce_d      = '0;
        grace_ended_d   = 1'b0;
        post_grace_d    = '0;
      end
      pbc_pkg::MODE_EVENT: begin
        if (cooldown_q != '0) begin
          if (release_hit) res_o.message = pbc_pkg::MSG_COOLING;
        end else if (grace_q != '0) begin
          if (release_hit) res_o.message = pbc_pkg::MSG_JUST_WOKE;
          grace_ended_d = 1'b0;
        end else if (grace_ended_q && from_wake_q && (post_grace_q != '0)) begin
          if (release_hit) res_o.message = pbc_pkg::MSG_STABILIZING;
        end else if (power) begin
          case (beat_i.key_value)
            pbc_pkg::KEY_RELEASE: begin
              if (press_pending_q) begin
                press_pending_d = 1'b0;
                press_age_d     = '0;
                if ((press_age_q >= cfg_i.min_press_ms) &&
                    (press_age_q < cfg_i.short_press_max_ms)) begin
                  res_o.action = pbc_pkg::ACT_SLEEP;
                  cooldown_d   = cfg_i.cooldown_ms;
                end
              end
            end
            pbc_pkg::KEY_PRESS: begin
              if (!press_pending_q) begin
                press_pending_d = 1'b1;
                press_age_d     = '0;
                debounce_d      = cfg_i.debounce_ms;
              end else if (debounce_q > pbc_pkg::RAPID_THRESH) begin
                res_o.message = pbc_pkg::MSG_TOO_RAPID;
              end
            end
            pbc_pkg::KEY_REPEAT: begin
              if (debounce_q == '0) begin
                debounce_d = cfg_i.debounce_ms;
                if (press_pending_q && (press_age_q >= cfg_i.short_press_max_ms)) begin
                  res_o.action    = pbc_pkg::ACT_SHUTDOWN;
                  cooldown_d      = cfg_i.cooldown_ms;
                  press_pending_d = 1'b0;
                  press_age_d     = '0;
                end
              end
            end
            default: ;  // undefined key value, no effect
          endcase
        end
      end
      default: ;  // undefined item kind, zero result
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_pending_q <= 1'b0;
      press_age_q     <= '0;
      cooldown_q      <= '0;
      grace_q         <= '0;
      post_grace_q    <= '0;
      grace_ended_q   <= 1'b0;
      from_wake_q     <= 1'b0;
      debounce_q      <= '0;
    end else if (adv_i) begin
      press_pending_q <= press_pending_d;
      press_age_q     <= press_age_d;
      cooldown_q      <= cooldown_d;
      grace_q         <= grace_d;
      post_grace_q    <= post_grace_d;
      grace_ended_q   <= grace_ended_d;
      from_wake_q     <= from_wake_d;
      debounce_q      <= debounce_d;
    end
  end

`ifndef SYNTHESIS
  // a request always arms the cooldown with the configured length
  a_req_arms_cooldown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (res_o.action != pbc_pkg::ACT_NONE) |=>
      cooldown_q == $past(cfg_i.cooldown_ms))
    else $error("request did not load cooldown");

  // a request never carries a user message
  a_req_no_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (res_o.action != pbc_pkg::ACT_NONE) |-> res_o.message == pbc_pkg::MSG_NONE)
    else $error("request with message");

  // without a press pending its age stays zero
  a_age_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !press_pending_q |-> press_age_q == '0)
    else $error("press age without pending press");

  // state only moves when a beat advances
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(cooldown_q) && $stable(grace_q) && $stable(press_age_q))
    else $error("state changed without a beat");
`endif

endmodule

// ----- sv/power_button_press_classifier.sv -----
// ----------------------------------------------------------------------------
// power_button_press_classifier: power key short press / long hold classifier
// turns tick, key event and wake beats into sleep or shutdown requests
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   mode, is_key_event, key_code, key_value
//   out_o    out  valid/ready   action, message
//   cfg      in   cfg_we_i      cfg_idx_i selects register, cfg_data_i value
//
// one beat per cycle sustained while out_o does not stall; a taken input beat
// passes input register, decision logic and result register before it is offered
// the decision logic and counter update in pbc_core sit between those registers
// reset clears all counters and flags and loads the default timings
// a stalled result holds in the output register while the input register
// keeps one more beat; only then does in_i drop ready
//
module power_button_press_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pbc_stream_if.sink                    in_i,
  pbc_stream_if.source                  out_o,
  input  logic                          cfg_we_i,
  input  logic [pbc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pbc_pkg::CfgDataW-1:0]  cfg_data_i
);

  pbc_pkg::cfg_t      cfg;
  pbc_pkg::in_beat_t  in_data_q;
  logic               in_valid_q;
  pbc_pkg::out_beat_t res;
  pbc_pkg::out_beat_t out_data_q;
  logic               out_valid_q;
  logic               adv;
  logic               in_take;

  // move a beat from the input register to the result register when the
  // result slot is empty or being emptied this cycle
  assign adv     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_take = in_i.valid && in_i.ready;

  assign in_i.ready  = !in_valid_q || adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  pbc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pbc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .beat_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_i.data;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= res;
    end
  end

`ifndef SYNTHESIS
  // a held input beat is never dropped while the result side stalls
  a_in_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_data_q))
    else $error("input beat lost under stall");

  // a result waiting on a stall is not overwritten
  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_data_q))
    else $error("stalled result overwritten");

  // ready drops only when both registers hold beats
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q)
    else $error("ready low with free slot");
`endif

endmodule
